/* hdl/sms_pkg.sv */
// sms_pkg: shared types and constants for the spi master shifter
`default_nettype none

package sms_pkg;

  // fixed field widths
  localparam int unsigned WORD_W = 16;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned SEL_W  = 4;

  // transfer lengths
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned WORD_BITS = 16;

  // request function codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } sms_func_t;

  // input request
  typedef struct packed {
    sms_func_t          func;
    logic [WORD_W-1:0]  tx_data;
    logic               wide_word;
    logic [MODE_W-1:0]  mode;
    logic [SEL_W-1:0]   select_index;
    logic               serial_in;
  } sms_in_t;

  // result
  typedef struct packed {
    logic               clock_out;
    logic               data_out;
    logic               select_active;
    logic [SEL_W-1:0]   select_line;
    logic [WORD_W-1:0]  received;
    logic               done_res;
    logic               mode_error;
    logic               busy_res;
  } sms_out_t;

endpackage

`default_nettype wire

/* hdl/sms_ifs.sv */
// sms_ifs: valid/ready channel interfaces for requests and results
`default_nettype none

interface sms_in_if;
  import sms_pkg::*;
  logic    valid;
  logic    ready;
  sms_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sms_out_if;
  import sms_pkg::*;
  logic     valid;
  logic     ready;
  sms_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/spi_master_shifter_top.sv */
// spi_master_shifter_top: spi master shifter for modes 0 to 3, msb first
//
//   channel  | dir | payload    | handshake
//   ---------+-----+------------+------------------------------
//   in_ch    | in  | sms_in_t   | valid/ready, one request
//   out_ch   | out | sms_out_t  | valid/ready, one result each
//
// One request is taken per cycle; its result goes to the output register,
// or to the skid entry if that register still holds an untaken result. The
// two-entry stage keeps in_ch.ready high while a single result waits,
// so a stall on out_ch stops requests only once both entries are full.
// rst_n is synchronous and returns the shifter to idle with all state zero.
`default_nettype none

module spi_master_shifter_top #(
  parameter int unsigned SELECT_LINES = 16,
  parameter int unsigned MAX_BITS     = 16
) (
  input  wire           clk,
  input  wire           rst_n,
  sms_in_if.sink        in_ch,
  sms_out_if.source     out_ch
);
  import sms_pkg::*;

  // word length capped at MAX_BITS
  localparam int unsigned WORD_LEN = (WORD_BITS > MAX_BITS) ? MAX_BITS : WORD_BITS;
  localparam int unsigned CNT_W    = $clog2(WORD_LEN + 1);

  // select index wrap, one entry per possible index
  localparam int unsigned SEL_CNT = 1 << SEL_W;
  logic [SEL_W-1:0] line_lut [SEL_CNT];

  for (genvar g = 0; g < SEL_CNT; g++) begin : g_lut
    assign line_lut[g] = SEL_W'(g % SELECT_LINES);
  end

  // shifter state
  logic [WORD_W-1:0] send_r, send_nxt;
  logic [WORD_W-1:0] recv_r, recv_nxt;
  logic [CNT_W-1:0]  bits_r, bits_nxt;
  logic              half_r, half_nxt;
  logic              active_r, active_nxt;
  logic              cpha_r, cpha_nxt;
  logic [SEL_W-1:0]  line_r, line_nxt;
  logic              sclk_r, sclk_nxt;
  logic              dout_r, dout_nxt;

  // output stage
  sms_out_t out_r, skid_r, res;
  logic     out_v_r, skid_v_r;

  logic              accept;
  logic              pop;
  logic [WORD_W-1:0] send_load;
  logic [WORD_W-1:0] recv_cap;
  logic [CNT_W-1:0]  bits_dec;
  logic [WORD_W-1:0] res_received;
  logic              res_done;
  logic              res_err;

  assign in_ch.ready = ~skid_v_r;
  assign accept      = in_ch.valid & in_ch.ready;
  assign pop         = out_v_r & out_ch.ready;

  assign send_load = in_ch.payload.wide_word ? in_ch.payload.tx_data
                   : {in_ch.payload.tx_data[BYTE_BITS-1:0], BYTE_BITS'(0)};
  assign recv_cap  = {recv_r[WORD_W-2:0], in_ch.payload.serial_in};
  assign bits_dec  = (bits_r != '0) ? bits_r - CNT_W'(1) : bits_r;

  // next state and result for one request
  always_comb begin
    send_nxt     = send_r;
    recv_nxt     = recv_r;
    bits_nxt     = bits_r;
    half_nxt     = half_r;
    active_nxt   = active_r;
    cpha_nxt     = cpha_r;
    line_nxt     = line_r;
    sclk_nxt     = sclk_r;
    dout_nxt     = dout_r;
    res_received = '0;
    res_done     = 1'b0;
    res_err      = 1'b0;
    if (accept) begin
      case (in_ch.payload.func)
        FUNC_START: begin
          if (!active_r) begin
            if (in_ch.payload.mode[2]) begin
              res_err      = 1'b1;
              res_done     = 1'b1;
              res_received = WORD_W'(1);
            end else begin
              send_nxt   = send_load;
              recv_nxt   = '0;
              bits_nxt   = in_ch.payload.wide_word ? CNT_W'(WORD_LEN) : CNT_W'(BYTE_BITS);
              half_nxt   = 1'b0;
              cpha_nxt   = in_ch.payload.mode[0];
              line_nxt   = line_lut[in_ch.payload.select_index];
              sclk_nxt   = in_ch.payload.mode[1];
              active_nxt = 1'b1;
              // phase 0 puts the first bit out before the first edge
              if (!in_ch.payload.mode[0]) begin
                dout_nxt = send_load[WORD_W-1];
                send_nxt = {send_load[WORD_W-2:0], 1'b0};
              end
            end
          end
        end
        FUNC_TICK: begin
          if (active_r) begin
            sclk_nxt = ~sclk_r;
            if (!half_r) begin
              // leading edge
              if (cpha_r) begin
                dout_nxt = send_r[WORD_W-1];
                send_nxt = {send_r[WORD_W-2:0], 1'b0};
              end else begin
                recv_nxt = recv_cap;
                bits_nxt = bits_dec;
              end
              half_nxt = 1'b1;
            end else begin
              // trailing edge
              if (cpha_r) begin
                recv_nxt = recv_cap;
                bits_nxt = bits_dec;
              end else if (bits_r != '0) begin
                dout_nxt = send_r[WORD_W-1];
                send_nxt = {send_r[WORD_W-2:0], 1'b0};
              end
              half_nxt = 1'b0;
              if (bits_nxt == '0) begin
                active_nxt   = 1'b0;
                res_done     = 1'b1;
                res_received = recv_nxt;
              end
            end
          end
        end
        default: begin
          sclk_nxt = sclk_r;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res.clock_out     = sclk_nxt;
    res.data_out      = dout_nxt;
    res.select_active = active_nxt;
    res.select_line   = line_nxt;
    res.received      = res_received;
    res.done_res      = res_done;
    res.mode_error    = res_err;
    res.busy_res      = active_nxt;
  end

  // shifter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_r   <= '0;
      recv_r   <= '0;
      bits_r   <= '0;
      half_r   <= 1'b0;
      active_r <= 1'b0;
      cpha_r   <= 1'b0;
      line_r   <= '0;
      sclk_r   <= 1'b0;
      dout_r   <= 1'b0;
    end else begin
      send_r   <= send_nxt;
      recv_r   <= recv_nxt;
      bits_r   <= bits_nxt;
      half_r   <= half_nxt;
      active_r <= active_nxt;
      cpha_r   <= cpha_nxt;
      line_r   <= line_nxt;
      sclk_r   <= sclk_nxt;
      dout_r   <= dout_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_v_r || pop) begin
        out_r   <= res;
        out_v_r <= 1'b1;
      end else begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = out_r;

endmodule

`default_nettype wire

/* hdl/sms_checker.sv */
// sms_checker: port-level checks for the spi master shifter
`default_nettype none

module sms_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_ready,
  input sms_pkg::sms_out_t  out_payload
);
  import sms_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // the transfer is over on the result that completes it
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.done_res |-> !out_payload.busy_res)
    else $error("done result still shows busy");

  // a bad mode reports done with received word one
  a_mode_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.mode_error |->
      out_payload.done_res && out_payload.received == WORD_W'(1))
    else $error("mode error result malformed");

  // select tracks busy
  a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.select_active == out_payload.busy_res)
    else $error("select and busy disagree");

  // received word shows only on a done result
  a_recv_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.received != '0 |-> out_payload.done_res)
    else $error("received word outside done result");

endmodule

bind spi_master_shifter_top sms_checker u_sms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

`default_nettype wire
